@@ hdl/sst_pkg.sv @@
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants for the sorted set table
// Table sizing, command codes, sequencer states and the compare result.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int DEPTH      = 64;
    localparam int ITEM_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef logic [ITEM_WIDTH-1:0] t_item;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CNT_W-1:0]      t_cnt;

    typedef enum logic [1:0] {
        CMD_INSERT   = 2'd0,
        CMD_ERASE    = 2'd1,
        CMD_CONTAINS = 2'd2,
        CMD_GET      = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHUP,
        S_SHDN,
        S_PLACE,
        S_GET
    } t_state;

    typedef struct packed {
        logic eq;
        logic lt;
    } t_cmp;

endpackage

@@ hdl/sst_ram.sv @@
// ----------------------------------------------------------------------------
// sst_ram: simple dual-port table memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sst_ram #(
    parameter int WIDTH = 32,
    parameter int WORDS = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(WORDS)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(WORDS)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [WORDS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ hdl/sst_cmp.sv @@
// ----------------------------------------------------------------------------
// sst_cmp: shared magnitude comparator
// Compares a table entry against the request value.
// ----------------------------------------------------------------------------
module sst_cmp (
    input  sst_pkg::t_item i_entry,
    input  sst_pkg::t_item i_key,
    output sst_pkg::t_cmp  o_res
);
    import sst_pkg::*;

    always_comb begin
        o_res.eq = (i_entry == i_key);
        o_res.lt = (i_entry < i_key);
    end
endmodule

@@ hdl/sorted_set_table.sv @@
// ----------------------------------------------------------------------------
// sorted_set_table: sorted set of distinct values in a fixed table
// Insert, erase, contains and get-by-position over an ascending table,
// driven by a small sequencer around one memory and one comparator.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy stays high
// until the result is ready, and the result is shown for exactly one cycle
// with o_done high. The receiver cannot stall, so sample it on that cycle.
// The table memory gives one registered read and one write per cycle. get
// reads the requested position as the request is taken. The other
// commands first scan upward from address 0, one word per cycle; the scan
// stops on the first entry not less than the value, or runs off the end
// after the last entry. contains then finishes; insert shifts the entries
// from the slot upward by one word and then places the value; erase shifts
// the entries above the found position down by one word.
// o_entry_count and o_is_empty reflect the count after the request.
// ----------------------------------------------------------------------------
module sorted_set_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_item_value,
    input  logic [5:0]  i_position,
    output logic        o_done,
    output logic        o_succeeded,
    output logic [31:0] o_read_value,
    output logic [6:0]  o_entry_count,
    output logic        o_is_empty
);
    import sst_pkg::*;

    // width wide enough to compare the position port against the count
    localparam int PW = CNT_W + 6;

    // control state
    t_state r_state, n_state;
    t_cnt   r_count, n_count;
    logic   r_done,  n_done;

    // request and scan bookkeeping
    t_cmd   r_cmd,   n_cmd;
    t_item  r_val,   n_val;
    t_cnt   r_ptr,   n_ptr;     // next memory address to read
    t_idx   r_didx,  n_didx;    // address of the word now on the read port
    logic   r_dvld,  n_dvld;    // read port holds a word requested last cycle
    t_cnt   r_slot,  n_slot;    // insert slot or erase position
    logic   r_found, n_found;   // scan hit or get position in range
    logic   r_ok,    n_ok;
    logic [31:0] r_rdval, n_rdval;

    // memory ports
    logic  mem_we;
    t_idx  mem_waddr;
    t_item mem_wdata;
    t_idx  mem_raddr;
    t_item mem_rdata;
    t_cmp  cmp_res;

    // scan results
    logic  scan_hit;
    logic  scan_end;

    sst_ram #(
        .WIDTH (ITEM_WIDTH),
        .WORDS (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    sst_cmp u_cmp (
        .i_entry (mem_rdata),
        .i_key   (r_val),
        .o_res   (cmp_res)
    );

    // first entry not below the value stops the scan (table is ascending)
    assign scan_hit = r_dvld && !cmp_res.lt;
    assign scan_end = !scan_hit && (r_ptr >= r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_val   <= n_val;
        r_ptr   <= n_ptr;
        r_didx  <= n_didx;
        r_dvld  <= n_dvld;
        r_slot  <= n_slot;
        r_found <= n_found;
        r_ok    <= n_ok;
        r_rdval <= n_rdval;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_done    = 1'b0;
        n_cmd     = r_cmd;
        n_val     = r_val;
        n_ptr     = r_ptr;
        n_didx    = r_didx;
        n_dvld    = 1'b0;
        n_slot    = r_slot;
        n_found   = r_found;
        n_ok      = r_ok;
        n_rdval   = r_rdval;
        mem_we    = 1'b0;
        mem_waddr = r_didx;
        mem_wdata = mem_rdata;
        mem_raddr = r_ptr[IDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                // get reads the requested position straight away
                mem_raddr = IDX_W'(i_position);
                if (start) begin
                    n_cmd   = t_cmd'(i_cmd);
                    n_val   = t_item'(64'(i_item_value));
                    n_ptr   = '0;
                    n_found = (PW'(i_position) < PW'(r_count));
                    n_rdval = '0;
                    if (t_cmd'(i_cmd) == CMD_GET) begin
                        n_state = S_GET;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                if (scan_hit || scan_end) begin
                    n_found = scan_hit && cmp_res.eq;
                    n_slot  = scan_hit ? t_cnt'(r_didx) : r_count;
                    case (r_cmd)
                        CMD_INSERT: begin
                            if ((scan_hit && cmp_res.eq) || (r_count == CNT_W'(DEPTH))) begin
                                n_ok    = 1'b0;
                                n_done  = 1'b1;
                                n_state = S_IDLE;
                            end else begin
                                n_ptr   = r_count;
                                n_state = S_SHUP;
                            end
                        end
                        CMD_ERASE: begin
                            if (scan_hit && cmp_res.eq) begin
                                n_ptr   = t_cnt'(r_didx) + 1'b1;
                                n_state = S_SHDN;
                            end else begin
                                n_ok    = 1'b0;
                                n_done  = 1'b1;
                                n_state = S_IDLE;
                            end
                        end
                        default: begin
                            n_ok    = scan_hit && cmp_res.eq;
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end
                    endcase
                end else begin
                    // keep one read in flight per cycle
                    n_dvld = 1'b1;
                    n_didx = r_ptr[IDX_W-1:0];
                    n_ptr  = r_ptr + 1'b1;
                end
            end

            S_SHUP: begin
                // word read from address a lands at a+1, walking downward
                mem_raddr = IDX_W'(r_ptr - 1'b1);
                mem_waddr = r_didx + 1'b1;
                mem_we    = r_dvld;
                if (r_ptr > r_slot) begin
                    n_dvld = 1'b1;
                    n_didx = IDX_W'(r_ptr - 1'b1);
                    n_ptr  = r_ptr - 1'b1;
                end else begin
                    n_state = S_PLACE;
                end
            end

            S_PLACE: begin
                mem_we    = 1'b1;
                mem_waddr = r_slot[IDX_W-1:0];
                mem_wdata = r_val;
                n_count   = r_count + 1'b1;
                n_ok      = 1'b1;
                n_done    = 1'b1;
                n_state   = S_IDLE;
            end

            S_SHDN: begin
                // word read from address a lands at a-1, walking upward
                mem_waddr = r_didx - 1'b1;
                mem_we    = r_dvld;
                if (r_ptr < r_count) begin
                    n_dvld = 1'b1;
                    n_didx = r_ptr[IDX_W-1:0];
                    n_ptr  = r_ptr + 1'b1;
                end else begin
                    n_count = r_count - 1'b1;
                    n_ok    = 1'b1;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_GET: begin
                n_ok    = r_found;
                n_rdval = r_found ? 32'(mem_rdata) : '0;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_succeeded   = r_ok;
    assign o_read_value  = r_rdval;
    assign o_entry_count = 7'(r_count);
    assign o_is_empty    = (r_count == '0);

endmodule
